@@ hdl/png_rf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the PNG row filter: sizes, field widths and the word passed
// from the position stage to the predictor stage. No dependencies.
package png_rf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int CHANNELS    = 3;
  localparam int STORE_DEPTH = MAX_WIDTH * CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
  localparam int CFG_W       = 11;
  localparam int BYTE_W      = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    byte_t             sample;
    logic              first_row;
    logic              plane_start;
    logic              last;
  } item_t;

endpackage

@@ hdl/png_rf_if.sv @@
`timescale 1ns / 1ps
// Stream interfaces of the PNG row filter: the raw byte channel and the
// filter result channel. Depends on png_rf_pkg.
interface png_rf_in_if
  import png_rf_pkg::*;
  ;
  logic  valid;
  logic  ready;
  byte_t sample;
  logic  frame_start;

  modport source (output valid, sample, frame_start, input ready);
  modport sink (input valid, sample, frame_start, output ready);
endinterface

interface png_rf_out_if
  import png_rf_pkg::*;
  ;
  logic  valid;
  logic  ready;
  byte_t none_out;
  byte_t sub_out;
  byte_t up_out;
  byte_t avg_out;
  byte_t paeth_out;
  logic  end_of_row;

  modport source (output valid, none_out, sub_out, up_out, avg_out, paeth_out,
                  end_of_row, input ready);
  modport sink (input valid, none_out, sub_out, up_out, avg_out, paeth_out,
                end_of_row, output ready);
endinterface

@@ hdl/png_rf_ctrl.sv @@
`timescale 1ns / 1ps
// Row position tracking and width register of the PNG row filter.
// Produces the line store address and plane flags of each accepted word. Uses png_rf_pkg.
module png_rf_ctrl
  import png_rf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             accept,
  input  byte_t            sample,
  input  logic             frame_start,
  output item_t            item
);

  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               first_row_r, first_row_nxt;
  logic [POS_W-1:0]   row_len;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_inc;
  logic               first_row;
  logic               plane_start;
  logic               last;

  always_comb begin
    width_nxt = width_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        width_nxt = WIDTH_W'(1);
      end else if (int'(cfg_wdata) > MAX_WIDTH) begin
        width_nxt = WIDTH_W'(MAX_WIDTH);
      end else begin
        width_nxt = WIDTH_W'(cfg_wdata);
      end
    end
  end

  assign row_len = POS_W'(CHANNELS * int'(width_r));

  always_comb begin
    pos = frame_start ? '0 : pos_r;
    if (pos >= row_len) begin
      pos = '0;
    end
    first_row   = frame_start | first_row_r;
    pos_inc     = pos + POS_W'(1);
    last        = (pos_inc == row_len);
    plane_start = 1'b0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (pos == POS_W'(k * int'(width_r))) begin
        plane_start = 1'b1;
      end
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    first_row_nxt = first_row_r;
    if (accept) begin
      pos_nxt       = last ? '0 : pos_inc;
      first_row_nxt = first_row & ~last;
    end
  end

  assign item.addr        = pos[ADDR_W-1:0];
  assign item.sample      = sample;
  assign item.first_row   = first_row;
  assign item.plane_start = plane_start;
  assign item.last        = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_W'(1);
      pos_r       <= '0;
      first_row_r <= 1'b1;
    end else begin
      width_r     <= width_nxt;
      pos_r       <= pos_nxt;
      first_row_r <= first_row_nxt;
    end
  end

endmodule

@@ hdl/png_rf_line_store.sv @@
`timescale 1ns / 1ps
// Line store of the PNG row filter: one row of bytes in a synchronous memory
// with a registered read and write-to-read forwarding. Uses png_rf_pkg.
module png_rf_line_store
  import png_rf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  byte_t             wr_data,
  output byte_t             rd_data
);

  byte_t mem [STORE_DEPTH];
  byte_t q_r;
  byte_t fwd_data_r;
  logic  fwd_r, fwd_nxt;

  assign fwd_nxt = rd_en ? (wr_en && (wr_addr == rd_addr)) : fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= fwd_nxt;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

@@ hdl/png_rf_predict.sv @@
`timescale 1ns / 1ps
// Predictor stage of the PNG row filter: forms the five filter residues from
// the byte above and the neighbour registers, and holds the output word. Uses png_rf_pkg.
module png_rf_predict
  import png_rf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  item_t             item,
  input  byte_t             above_raw,
  output logic              in_ready,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output byte_t             wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output byte_t             none_out,
  output byte_t             sub_out,
  output byte_t             up_out,
  output byte_t             avg_out,
  output byte_t             paeth_out,
  output logic              end_of_row
);

  item_t       item_r;
  logic        s1_v_r, s1_v_nxt;
  logic        out_v_r, out_v_nxt;
  logic        s1_adv;
  byte_t       left_r, upleft_r;
  byte_t       a, b, c, pred;
  logic [8:0]  avg_sum;
  logic signed [9:0] d_pa, d_pb, d_pc;
  logic [9:0]  pa, pb, pc;
  byte_t       none_r, sub_r, up_r, avg_r, paeth_r;
  logic        eor_r;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  assign s1_v_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  assign wr_en   = s1_adv;
  assign wr_addr = item_r.addr;
  assign wr_data = item_r.sample;

  always_comb begin
    a = item_r.plane_start ? '0 : left_r;
    b = item_r.first_row ? '0 : above_raw;
    c = (item_r.plane_start || item_r.first_row) ? '0 : upleft_r;
    avg_sum = {1'b0, a} + {1'b0, b};
    d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
    d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
    d_pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
    pb = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
    pc = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);
    if (pa <= pb && pa <= pc) begin
      pred = a;
    end else if (pb <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
    if (s1_adv) begin
      left_r   <= item_r.sample;
      upleft_r <= b;
      none_r   <= item_r.sample;
      sub_r    <= item_r.sample - a;
      up_r     <= item_r.sample - b;
      avg_r    <= item_r.sample - avg_sum[8:1];
      paeth_r  <= item_r.sample - pred;
      eor_r    <= item_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign none_out   = none_r;
  assign sub_out    = sub_r;
  assign up_out     = up_r;
  assign avg_out    = avg_r;
  assign paeth_out  = paeth_r;
  assign end_of_row = eor_r;

endmodule

@@ hdl/png_row_filter_all_types.sv @@
`timescale 1ns / 1ps
// Top level of the PNG row filter, producing all five filter residues per byte.
// Depends on png_rf_pkg, png_rf_if, png_rf_ctrl, png_rf_line_store and png_rf_predict.
//
// The block takes one byte per clock cycle unless the output channel stalls, and
// delivers one result word per byte: the byte is registered in the predictor
// input stage, then its residues in the output registers. The line store, a 3072
// by 8 bit memory with one read port and one write port, is read when a byte enters
// and written when its result is formed. It is not cleared after reset: the first
// row of a frame ignores what it reads, so bytes are accepted straight out of reset.
module png_row_filter_all_types
  import png_rf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  png_rf_in_if.sink         in_ch,
  png_rf_out_if.source      out_ch,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic              accept;
  logic              in_ready;
  item_t             item;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  byte_t             wr_data;
  byte_t             rd_data;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid & in_ready;

  png_rf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .sample      (in_ch.sample),
    .frame_start (in_ch.frame_start),
    .item        (item)
  );

  png_rf_line_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (item.addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  png_rf_predict u_predict (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (item),
    .above_raw  (rd_data),
    .in_ready   (in_ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .none_out   (out_ch.none_out),
    .sub_out    (out_ch.sub_out),
    .up_out     (out_ch.up_out),
    .avg_out    (out_ch.avg_out),
    .paeth_out  (out_ch.paeth_out),
    .end_of_row (out_ch.end_of_row)
  );

endmodule
